FILE: src/adpe_pkg.sv
`timescale 1ns / 1ps

package adpe_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_SUB = 4'd1;
   localparam logic [3:0] FUNC_AND = 4'd2;
   localparam logic [3:0] FUNC_BIC = 4'd3;
   localparam logic [3:0] FUNC_ORR = 4'd4;
   localparam logic [3:0] FUNC_EOR = 4'd5;
   localparam logic [3:0] FUNC_CMP = 4'd6;
   localparam logic [3:0] FUNC_CMN = 4'd7;
   localparam logic [3:0] FUNC_TST = 4'd8;
   localparam logic [3:0] FUNC_MOV = 4'd9;

   localparam logic [3:0] COND_ALWAYS = 4'hE;

   localparam logic [7:0] OPC_ADD_IMM = 8'h28;
   localparam logic [7:0] OPC_SUB_IMM = 8'h24;
   localparam logic [7:0] OPC_AND_IMM = 8'h20;
   localparam logic [7:0] OPC_BIC_IMM = 8'h3c;
   localparam logic [7:0] OPC_ORR_IMM = 8'h38;
   localparam logic [7:0] OPC_EOR_IMM = 8'h22;
   localparam logic [7:0] OPC_CMP_IMM = 8'h35;
   localparam logic [7:0] OPC_CMN_IMM = 8'h37;
   localparam logic [7:0] OPC_TST_IMM = 8'h31;
   localparam logic [7:0] OPC_MOV_IMM = 8'h3a;
   localparam logic [7:0] OPC_MOVW    = 8'h30;
   localparam logic [7:0] OPC_MOVT    = 8'h34;

   localparam logic [7:0] OPC_ADD_REG = 8'h08;
   localparam logic [7:0] OPC_SUB_REG = 8'h04;
   localparam logic [7:0] OPC_AND_REG = 8'h00;
   localparam logic [7:0] OPC_BIC_REG = 8'h1c;
   localparam logic [7:0] OPC_ORR_REG = 8'h18;
   localparam logic [7:0] OPC_EOR_REG = 8'h02;
   localparam logic [7:0] OPC_CMP_REG = 8'h15;
   localparam logic [7:0] OPC_CMN_REG = 8'h17;
   localparam logic [7:0] OPC_TST_REG = 8'h11;

   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][31:0] words;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] enc;
   } imm_enc_type;

   function automatic imm_enc_type encode_imm(input logic [31:0] v);
      logic [31:0] s;
      logic [4:0]  sh;
      logic [5:0]  rot;
      imm_enc_type r;
      s  = v;
      sh = 5'd0;
      if (s[15:0] == 16'd0) begin
         sh = sh + 5'd16;
         s  = s >> 16;
      end
      if (s[7:0] == 8'd0) begin
         sh = sh + 5'd8;
         s  = s >> 8;
      end
      if (s[3:0] == 4'd0) begin
         sh = sh + 5'd4;
         s  = s >> 4;
      end
      if (s[1:0] == 2'd0) begin
         sh = sh + 5'd2;
         s  = s >> 2;
      end
      rot   = 6'd32 - {1'b0, sh};
      r.ok  = (s[31:8] == 24'd0);
      r.enc = {rot[4:1], s[7:0]};
      return r;
   endfunction

   function automatic logic [31:0] wide_word(input logic [7:0] opc, input logic [3:0] rd,
                                             input logic [15:0] h);
      return {COND_ALWAYS, opc, h[15:12], rd, h[11:0]};
   endfunction

endpackage

FILE: src/adpe_front.sv
`timescale 1ns / 1ps

module adpe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [3:0]           req_func,
   input  logic [3:0]           req_dest_reg,
   input  logic [3:0]           req_source_reg,
   input  logic [31:0]          req_immediate,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data,
   output adpe_pkg::push_type   push
);
   import adpe_pkg::*;

   logic [3:0]  temp_reg_ff, temp_reg_in;
   logic [3:0]  f;
   logic [31:0] v;
   logic        neg;
   logic [7:0]  imm_opc, reg_opc, inv_opc;
   logic [3:0]  rdf;
   imm_enc_type enc_pos, enc_inv;
   logic        high_nz;
   desc_type    d;

   always_comb begin
      temp_reg_in = csr_write_enable ? csr_write_data : temp_reg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_reg_ff <= 4'd12;
      end else begin
         temp_reg_ff <= temp_reg_in;
      end
   end

   always_comb begin
      neg = (req_func == FUNC_ADD || req_func == FUNC_SUB || req_func == FUNC_CMP ||
             req_func == FUNC_CMN) && req_immediate[31] && (req_immediate[30:0] != 31'd0);
      f = req_func;
      v = req_immediate;
      if (neg) begin
         v = 32'd0 - req_immediate;
         case (req_func)
            FUNC_ADD: f = FUNC_SUB;
            FUNC_SUB: f = FUNC_ADD;
            FUNC_CMP: f = FUNC_CMN;
            default:  f = FUNC_CMP;
         endcase
      end

      case (f)
         FUNC_ADD: begin imm_opc = OPC_ADD_IMM; reg_opc = OPC_ADD_REG; end
         FUNC_SUB: begin imm_opc = OPC_SUB_IMM; reg_opc = OPC_SUB_REG; end
         FUNC_AND: begin imm_opc = OPC_AND_IMM; reg_opc = OPC_AND_REG; end
         FUNC_BIC: begin imm_opc = OPC_BIC_IMM; reg_opc = OPC_BIC_REG; end
         FUNC_ORR: begin imm_opc = OPC_ORR_IMM; reg_opc = OPC_ORR_REG; end
         FUNC_EOR: begin imm_opc = OPC_EOR_IMM; reg_opc = OPC_EOR_REG; end
         FUNC_CMP: begin imm_opc = OPC_CMP_IMM; reg_opc = OPC_CMP_REG; end
         FUNC_CMN: begin imm_opc = OPC_CMN_IMM; reg_opc = OPC_CMN_REG; end
         default:  begin imm_opc = OPC_TST_IMM; reg_opc = OPC_TST_REG; end
      endcase
      inv_opc = (f == FUNC_AND) ? OPC_BIC_IMM : OPC_AND_IMM;
      rdf     = (f >= FUNC_CMP) ? 4'd0 : req_dest_reg;

      enc_pos = encode_imm(v);
      enc_inv = encode_imm(~v);
      high_nz = (v[31:16] != 16'd0);

      d.count    = 2'd1;
      d.words[1] = '0;
      d.words[2] = '0;
      if (req_func == FUNC_MOV) begin
         if (enc_pos.ok) begin
            d.words[0] = {COND_ALWAYS, OPC_MOV_IMM, 4'd0, req_dest_reg, enc_pos.enc};
         end else begin
            d.words[0] = wide_word(OPC_MOVW, req_dest_reg, v[15:0]);
            d.words[1] = wide_word(OPC_MOVT, req_dest_reg, v[31:16]);
            d.count    = high_nz ? 2'd2 : 2'd1;
         end
      end else if (enc_pos.ok) begin
         d.words[0] = {COND_ALWAYS, imm_opc, req_source_reg, rdf, enc_pos.enc};
      end else if ((f == FUNC_AND || f == FUNC_BIC) && enc_inv.ok) begin
         d.words[0] = {COND_ALWAYS, inv_opc, req_source_reg, rdf, enc_inv.enc};
      end else begin
         d.words[0] = wide_word(OPC_MOVW, temp_reg_ff, v[15:0]);
         if (high_nz) begin
            d.words[1] = wide_word(OPC_MOVT, temp_reg_ff, v[31:16]);
            d.words[2] = {COND_ALWAYS, reg_opc, req_source_reg, rdf, 8'd0, temp_reg_ff};
            d.count    = 2'd3;
         end else begin
            d.words[1] = {COND_ALWAYS, reg_opc, req_source_reg, rdf, 8'd0, temp_reg_ff};
            d.count    = 2'd2;
         end
      end

      push.valid = accept && (req_func <= FUNC_MOV);
      push.desc  = d;
   end

endmodule

FILE: src/adpe_queue.sv
`timescale 1ns / 1ps

module adpe_queue #(
   parameter int DEPTH = adpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  adpe_pkg::push_type   push,
   input  logic                 pop,
   output adpe_pkg::desc_type   head,
   output logic                 not_empty,
   output logic                 full
);
   import adpe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.desc;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

endmodule

FILE: src/adpe_back.sv
`timescale 1ns / 1ps

module adpe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  adpe_pkg::desc_type   head,
   input  logic                 not_empty,
   output logic                 pop,
   output logic                 rsp_strobe,
   output logic [31:0]          rsp_word,
   output logic                 rsp_last
);
   import adpe_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       at_end;

   always_comb begin
      at_end     = (idx_ff == head.count - 2'd1);
      rsp_strobe = not_empty;
      rsp_word   = head.words[idx_ff];
      rsp_last   = at_end;
      pop        = not_empty && at_end;
      idx_in     = idx_ff;
      if (not_empty) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> (idx_ff == 2'd0))
      else $error("word index did not restart after final beat");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (idx_ff == $past(idx_ff) + 2'd1) && rsp_strobe)
      else $error("request interrupted before its final beat");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (idx_ff < head.count))
      else $error("word index beyond request length");

endmodule

FILE: src/arm_data_processing_emitter.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// request   req_func, req_dest_reg, req_source_reg, start high and busy low
//           req_immediate
// result    rsp_word, rsp_last                      rsp_strobe, high with each beat
// config    csr_write_data                          csr_write_enable
//
// A request is classified combinationally on entry to the queue and emits one to three
// result beats, one per cycle, so the sustained request rate is set by the single-beat
// result port.
// Reset is synchronous and active high; temp_reg returns to 12 and the queue empties.
// The receiver cannot stall; busy rises only while the request queue is full.

module arm_data_processing_emitter #(
   parameter int QUEUE_DEPTH = adpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_func,
   input  logic [3:0]  req_dest_reg,
   input  logic [3:0]  req_source_reg,
   input  logic [31:0] req_immediate,
   output logic        rsp_strobe,
   output logic [31:0] rsp_word,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data
);
   import adpe_pkg::*;

   push_type push;
   desc_type head;
   logic     not_empty, full, pop;

   assign busy = full;

   adpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (start && !busy),
      .req_func         (req_func),
      .req_dest_reg     (req_dest_reg),
      .req_source_reg   (req_source_reg),
      .req_immediate    (req_immediate),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   adpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   adpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_last)
   );

endmodule
